@@ rtl/itoa_pkg.sv @@
package itoa_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } itoa_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } itoa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quot_zero;
    logic negative;
    logic last_digit;
  } itoa_status_t;

endpackage

@@ rtl/itoa_dp.sv @@
module itoa_dp
  import itoa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  itoa_cmd_t                  cmd,
  input  logic signed [VALUE_W-1:0]  in_value,
  output itoa_status_t               status,
  output logic                       out_valid,
  output logic        [CHAR_W-1:0]   out_character,
  output logic                       out_last_char
);

  logic [VALUE_W-1:0]   mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0]   digits_r [MAX_DIGITS];
  logic [DIGIT_W-1:0]   digits_nxt [MAX_DIGITS];
  logic                 valid_r, valid_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic                 last_r, last_nxt;

  logic [VALUE_W-1:0]   raw;
  logic [VALUE_W-1:0]   mag_load;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   diff;
  logic [DIGIT_W-1:0]   rem;

  assign raw      = $unsigned(in_value);
  assign mag_load = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

  // Divide by ten through the reciprocal, then recover the remainder
  assign prod     = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot     = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign diff     = mag_r - quot_x10;
  assign rem      = diff[DIGIT_W-1:0];

  assign status.quot_zero  = (quot == '0);
  assign status.negative   = neg_r;
  assign status.last_digit = (cnt_r == CNT_W'(1));

  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    valid_nxt = 1'b0;
    char_nxt  = char_r;
    last_nxt  = last_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digits_nxt[i] = digits_r[i];
    end
    if (cmd.load) begin
      mag_nxt = mag_load;
      neg_nxt = raw[VALUE_W-1];
      cnt_nxt = '0;
    end else if (cmd.div_step) begin
      // newest digit enters at the head, so the head ends up most significant
      mag_nxt       = quot;
      cnt_nxt       = cnt_r + CNT_W'(1);
      digits_nxt[0] = rem;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digits_nxt[i] = digits_r[i-1];
      end
    end else if (cmd.emit_sign) begin
      valid_nxt = 1'b1;
      char_nxt  = ASCII_MINUS;
      last_nxt  = 1'b0;
    end else if (cmd.emit_digit) begin
      valid_nxt = 1'b1;
      char_nxt  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_r[0]};
      last_nxt  = (cnt_r == CNT_W'(1));
      cnt_nxt   = cnt_r - CNT_W'(1);
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digits_nxt[i] = digits_r[i+1];
      end
      digits_nxt[MAX_DIGITS-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      digits_r[i] <= digits_nxt[i];
    end
  end

  assign out_valid     = valid_r;
  assign out_character = char_r;
  assign out_last_char = last_r;

endmodule

@@ rtl/itoa_ctrl.sv @@
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  itoa_status_t status,
  output itoa_cmd_t    cmd,
  output logic         busy
);

  itoa_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.quot_zero) begin
          state_nxt = status.negative ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/int_to_decimal_ascii.sv @@
// Signed 32-bit integer to decimal ASCII text.
//
// Input channel: drive in_value and raise start; the beat is taken at a
// rising edge where start is high and busy is low. busy stays high until the
// text of that number has been handed out.
// Result channel: one character per beat on out_character, marked by the
// out_valid strobe for exactly one cycle; out_last_char flags the final
// character. Text runs most significant first, with a leading '-' for a
// negative value. Zero gives "0"; the most negative value gives eleven chars.
// In order, the divider takes one reciprocal multiply per digit, least
// significant digit first; a negative value then passes the sign state,
// then the digits are emitted, each character registered from its emit
// step. A new number can be taken in the cycle the last character shows.
// Reset (synchronous, rst_n low) returns the controller to idle and drops any
// strobe. The receiver cannot stall: every strobed beat is taken as shown.
module int_to_decimal_ascii
  import itoa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  output logic        [CHAR_W-1:0]  out_character,
  output logic                      out_last_char
);

  // command and status are the only link between controller and datapath
  itoa_cmd_t    cmd;
  itoa_status_t status;

  itoa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  itoa_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_value),
    .status        (status),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last_char (out_last_char)
  );

endmodule

@@ rtl/itoa_chk.sv @@
module itoa_chk
  import itoa_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last_char
);

  // Reset leaves the block idle with no strobe
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // An accepted number makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // No character appears right after a number is taken
  a_accept_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid)
    else $error("character strobed right after accept");

  // A run of characters has no gaps until its last character
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |=> out_valid)
    else $error("gap inside a character run");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == ASCII_MINUS) |-> !out_last_char)
    else $error("minus sign flagged as last");

endmodule

bind int_to_decimal_ascii itoa_chk u_itoa_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_character (out_character),
  .out_last_char (out_last_char)
);
